[hdl/tilemap_scroll_edge_streamer_unit_defines.svh]
// assertion macros for the tilemap scroll edge streamer
// no dependencies; included by files that carry assertions
`ifndef TILEMAP_SCROLL_EDGE_STREAMER_UNIT_DEFINES_SVH
`define TILEMAP_SCROLL_EDGE_STREAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TSES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tses assertion failed");
`define TSES_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tses assertion failed");
`else
`define TSES_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSES_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/tses_pkg.sv]
// shared types and constants for the tilemap scroll edge streamer
// no dependencies
package tses_pkg;

    typedef logic signed [14:0] t_line;
    typedef logic [5:0]         t_cnt;

    typedef struct packed {
        t_line a;
        t_line b;
        logic  sub;
    } t_alu_req;

    typedef struct packed {
        logic we_x;
        logic we_y;
    } t_pos_wr;

    localparam int EDGE_LO   = 3;
    localparam int EDGE_HI_X = 32;
    localparam int EDGE_HI_Y = 22;
    localparam int MAX_COLS  = 36;
    localparam int MAX_ROWS  = 26;

    localparam logic KIND_COL = 1'b0;
    localparam logic KIND_ROW = 1'b1;

endpackage

[hdl/tses_alu.sv]
// shared add/subtract unit for tile edges, differences, magnitudes and line stepping
// depends on tses_pkg
module tses_alu import tses_pkg::*; (
    input  t_alu_req i_req,
    output t_line    o_res
);

    assign o_res = i_req.sub ? t_line'(i_req.a - i_req.b) : t_line'(i_req.a + i_req.b);

endmodule

[hdl/tses_pos_store.sv]
// per-layer store of the last redrawn scroll positions, reset to zero
// depends on tses_pkg
module tses_pos_store import tses_pkg::*; #(
    parameter int NUM_LAYERS = 2,
    parameter int LAYER_W    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LAYER_W-1:0] i_idx,
    input  t_pos_wr            i_wr,
    input  logic [15:0]        i_x,
    input  logic [15:0]        i_y,
    output logic [15:0]        o_x,
    output logic [15:0]        o_y
);

    logic [15:0] r_x [NUM_LAYERS];
    logic [15:0] r_y [NUM_LAYERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                r_x[i] <= '0;
                r_y[i] <= '0;
            end
        end else begin
            if (i_wr.we_x) begin
                r_x[i_idx] <= i_x;
            end
            if (i_wr.we_y) begin
                r_y[i_idx] <= i_y;
            end
        end
    end

    assign o_x = r_x[i_idx];
    assign o_y = r_y[i_idx];

endmodule

[hdl/tilemap_scroll_edge_streamer_unit.sv]
// top level of the tilemap scroll edge streamer: sequencer, output register
// depends on tses_pkg, tses_alu, tses_pos_store and the defines header
`include "tilemap_scroll_edge_streamer_unit_defines.svh"

// Takes one scroll update (layer, x, y in pixels) per request and streams the
// tile column and row redraw commands it causes, columns first, tlast on the
// final one; an update that changes no tile coordinate yields no command.
// One shared adder computes the window edges, the tile differences and their
// magnitudes in states S_X0 to S_AY after the request is taken, then steps the
// line number once per emitted command. The input is not ready until the last
// command of an update is loaded into the output register.
module tilemap_scroll_edge_streamer_unit import tses_pkg::*; #(
    parameter int NUM_LAYERS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // scroll_x, scroll_y
    input  logic [0:0]  i_s_axis_tuser,  // layer
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // line_index, span_first, span_end
    output logic [1:0]  o_m_axis_tuser,  // out_layer, kind
    output logic        o_m_axis_tlast   // last
);

    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_X0   = 4'd1;
    localparam logic [3:0] S_X1   = 4'd2;
    localparam logic [3:0] S_Y0   = 4'd3;
    localparam logic [3:0] S_Y1   = 4'd4;
    localparam logic [3:0] S_DX   = 4'd5;
    localparam logic [3:0] S_AX   = 4'd6;
    localparam logic [3:0] S_DY   = 4'd7;
    localparam logic [3:0] S_AY   = 4'd8;
    localparam logic [3:0] S_EX   = 4'd9;
    localparam logic [3:0] S_EY   = 4'd10;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic        r_layer;
    logic [15:0] r_sx;
    logic [15:0] r_sy;
    t_line       r_x0;
    t_line       r_x1;
    t_line       r_y0;
    t_line       r_y1;
    t_line       r_d;
    t_line       r_line;
    t_cnt        r_cnt_x;
    t_cnt        r_cnt_y;
    logic        r_neg_x;
    logic        r_neg_y;
    logic        r_ovalid;
    logic [47:0] r_odata;
    logic [1:0]  r_ouser;
    logic        r_olast;

    t_alu_req    w_req;
    t_line       w_res;
    t_pos_wr     w_wr;
    logic [15:0] w_dx;
    logic [15:0] w_dy;
    t_line       w_tx;
    t_line       w_ty;
    t_line       w_lim;
    t_cnt        w_cnt;
    logic        w_in_acc;
    logic        w_lay_ok;
    logic        w_slot;
    logic        w_load;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_lay_ok = 32'(i_s_axis_tuser) < 32'(NUM_LAYERS);
    assign w_slot   = !r_ovalid || i_m_axis_tready;
    assign w_load   = w_slot && (r_state == S_EX || r_state == S_EY);
    assign w_tx     = t_line'({2'b00, r_sx[15:3]});
    assign w_ty     = t_line'({2'b00, r_sy[15:3]});

    tses_alu u_alu (
        .i_req (w_req),
        .o_res (w_res)
    );

    tses_pos_store #(
        .NUM_LAYERS (NUM_LAYERS),
        .LAYER_W    (LAYER_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (LAYER_W'(r_layer)),
        .i_wr    (w_wr),
        .i_x     (r_sx),
        .i_y     (r_sy),
        .o_x     (w_dx),
        .o_y     (w_dy)
    );

    // shared adder operand select
    always_comb begin
        w_req.a   = '0;
        w_req.b   = '0;
        w_req.sub = 1'b0;
        case (r_state)
            S_X0: begin
                w_req.a   = w_tx;
                w_req.b   = t_line'(EDGE_LO);
                w_req.sub = 1'b1;
            end
            S_X1: begin
                w_req.a = w_tx;
                w_req.b = t_line'(EDGE_HI_X);
            end
            S_Y0: begin
                w_req.a   = w_ty;
                w_req.b   = t_line'(EDGE_LO);
                w_req.sub = 1'b1;
            end
            S_Y1: begin
                w_req.a = w_ty;
                w_req.b = t_line'(EDGE_HI_Y);
            end
            S_DX: begin
                w_req.a   = w_tx;
                w_req.b   = t_line'({2'b00, w_dx[15:3]});
                w_req.sub = 1'b1;
            end
            S_DY: begin
                w_req.a   = w_ty;
                w_req.b   = t_line'({2'b00, w_dy[15:3]});
                w_req.sub = 1'b1;
            end
            S_AX, S_AY: begin
                w_req.a   = r_d[14] ? t_line'(0) : r_d;
                w_req.b   = r_d[14] ? r_d : t_line'(0);
                w_req.sub = r_d[14];
            end
            S_EX: begin
                w_req.a   = r_line;
                w_req.b   = t_line'(1);
                w_req.sub = !r_neg_x;
            end
            S_EY: begin
                w_req.a   = r_line;
                w_req.b   = t_line'(1);
                w_req.sub = !r_neg_y;
            end
            default: begin
                w_req.sub = 1'b0;
            end
        endcase
    end

    // saturate the magnitude to the window size
    assign w_lim = (r_state == S_AY) ? t_line'(MAX_ROWS) : t_line'(MAX_COLS);
    assign w_cnt = (w_res > w_lim) ? t_cnt'(w_lim) : w_res[5:0];

    assign w_wr.we_x = (r_state == S_AY) && (r_cnt_x != '0);
    assign w_wr.we_y = (r_state == S_AY) && (w_cnt != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_lay_ok) begin
                    n_state = S_X0;
                end
            end
            S_X0: n_state = S_X1;
            S_X1: n_state = S_Y0;
            S_Y0: n_state = S_Y1;
            S_Y1: n_state = S_DX;
            S_DX: n_state = S_AX;
            S_AX: n_state = S_DY;
            S_DY: n_state = S_AY;
            S_AY: begin
                if (r_cnt_x != '0) begin
                    n_state = S_EX;
                end else if (w_cnt != '0) begin
                    n_state = S_EY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EX: begin
                if (w_slot && r_cnt_x == t_cnt'(1)) begin
                    n_state = (r_cnt_y != '0) ? S_EY : S_IDLE;
                end
            end
            S_EY: begin
                if (w_slot && r_cnt_y == t_cnt'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt_x  <= '0;
            r_cnt_y  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= w_load || (r_ovalid && !i_m_axis_tready);
            case (r_state)
                S_AX: r_cnt_x <= w_cnt;
                S_AY: r_cnt_y <= w_cnt;
                S_EX: begin
                    if (w_slot) begin
                        r_cnt_x <= r_cnt_x - t_cnt'(1);
                    end
                end
                S_EY: begin
                    if (w_slot) begin
                        r_cnt_y <= r_cnt_y - t_cnt'(1);
                    end
                end
                default: r_cnt_x <= r_cnt_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_layer <= i_s_axis_tuser[0];
                    r_sx    <= i_s_axis_tdata[15:0];
                    r_sy    <= i_s_axis_tdata[31:16];
                end
            end
            S_X0: r_x0 <= w_res;
            S_X1: r_x1 <= w_res;
            S_Y0: r_y0 <= w_res;
            S_Y1: r_y1 <= w_res;
            S_DX: r_d  <= w_res;
            S_DY: r_d  <= w_res;
            S_AX: r_neg_x <= r_d[14];
            S_AY: begin
                r_neg_y <= r_d[14];
                if (r_cnt_x != '0) begin
                    r_line <= r_neg_x ? r_x0 : r_x1;
                end else begin
                    r_line <= r_d[14] ? r_y0 : r_y1;
                end
            end
            S_EX: begin
                if (w_slot) begin
                    r_line <= (r_cnt_x == t_cnt'(1)) ? (r_neg_y ? r_y0 : r_y1) : w_res;
                end
            end
            S_EY: begin
                if (w_slot) begin
                    r_line <= w_res;
                end
            end
            default: r_line <= r_line;
        endcase
        if (w_load) begin
            if (r_state == S_EX) begin
                r_odata <= {3'b000, r_y1, r_y0, r_line};
                r_ouser <= {KIND_COL, r_layer};
                r_olast <= (r_cnt_x == t_cnt'(1)) && (r_cnt_y == '0);
            end else begin
                r_odata <= {3'b000, r_x1, r_x0, r_line};
                r_ouser <= {KIND_ROW, r_layer};
                r_olast <= (r_cnt_y == t_cnt'(1));
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    `TSES_ASSERT_IMP(a_cnt_x_sat, i_clk, i_rst_n, 1'b1, r_cnt_x <= t_cnt'(MAX_COLS))
    `TSES_ASSERT_IMP(a_cnt_y_sat, i_clk, i_rst_n, 1'b1, r_cnt_y <= t_cnt'(MAX_ROWS))
    `TSES_ASSERT_IMP(a_col_busy, i_clk, i_rst_n, r_state == S_EX, r_cnt_x != '0)
    `TSES_ASSERT_IMP(a_row_after_col, i_clk, i_rst_n, r_state == S_EY, r_cnt_x == '0)
    `TSES_ASSERT_IMP(a_row_busy, i_clk, i_rst_n, r_state == S_EY, r_cnt_y != '0)
    `TSES_ASSERT_NXT(a_start, i_clk, i_rst_n, w_in_acc, r_state == S_X0 || r_state == S_IDLE)

endmodule

[dv/tb_tilemap_scroll_edge_streamer_unit.sv]
// testbench for tilemap_scroll_edge_streamer_unit: directed and random scroll updates
// predicts column and row redraw commands per layer and checks each command in order
// depends on tses_pkg and the block under test
module tb_tilemap_scroll_edge_streamer_unit;
    import tses_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic        layer;
        logic [15:0] sx;
        logic [15:0] sy;
    } scroll_upd_t;

    typedef struct packed {
        logic  out_layer;
        logic  kind;
        t_line line_index;
        t_line span_first;
        t_line span_end;
        logic  last;
    } redraw_cmd_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    scroll_upd_t pend_q[$];
    redraw_cmd_t redraw_q[$];
    logic [15:0] redrawn_x[2];
    logic [15:0] redrawn_y[2];
    logic [15:0] sent_x[2];
    logic [15:0] sent_y[2];
    int          send_idle_pct = 27;
    int          recv_idle_pct = 88;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          error_cnt = 0;
    int          cycle_cnt = 0;

    tilemap_scroll_edge_streamer_unit #(
        .NUM_LAYERS (2)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // scroll_x, scroll_y
        .i_s_axis_tuser  (s_tuser),   // layer
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // line_index, span_first, span_end
        .o_m_axis_tuser  (m_tuser),   // out_layer, kind
        .o_m_axis_tlast  (m_tlast)    // last
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        error_cnt++;
    endtask

    task automatic predict_redraw(input logic lay, input logic [15:0] sx,
                                  input logic [15:0] sy);
        int          tx;
        int          ty;
        int          dx;
        int          dy;
        int          ncol;
        int          nrow;
        int          total;
        redraw_cmd_t cmd;
        tx = int'(sx[15:3]);
        ty = int'(sy[15:3]);
        dx = tx - int'(redrawn_x[lay][15:3]);
        dy = ty - int'(redrawn_y[lay][15:3]);
        ncol = (dx < 0) ? -dx : dx;
        nrow = (dy < 0) ? -dy : dy;
        if (ncol > MAX_COLS) ncol = MAX_COLS;
        if (nrow > MAX_ROWS) nrow = MAX_ROWS;
        total = ncol + nrow;
        for (int i = 0; i < ncol; i++) begin
            cmd.out_layer  = lay;
            cmd.kind       = KIND_COL;
            cmd.line_index = t_line'((dx > 0) ? tx + EDGE_HI_X - i : tx - EDGE_LO + i);
            cmd.span_first = t_line'(ty - EDGE_LO);
            cmd.span_end   = t_line'(ty + EDGE_HI_Y);
            cmd.last       = (i == total - 1);
            redraw_q.push_back(cmd);
        end
        for (int i = 0; i < nrow; i++) begin
            cmd.out_layer  = lay;
            cmd.kind       = KIND_ROW;
            cmd.line_index = t_line'((dy > 0) ? ty + EDGE_HI_Y - i : ty - EDGE_LO + i);
            cmd.span_first = t_line'(tx - EDGE_LO);
            cmd.span_end   = t_line'(tx + EDGE_HI_X);
            cmd.last       = (ncol + i == total - 1);
            redraw_q.push_back(cmd);
        end
        if (ncol > 0) redrawn_x[lay] = sx;
        if (nrow > 0) redrawn_y[lay] = sy;
    endtask

    task automatic queue_update(input logic lay, input logic [15:0] sx, input logic [15:0] sy);
        scroll_upd_t upd;
        upd.layer = lay;
        upd.sx    = sx;
        upd.sy    = sy;
        pend_q.push_back(upd);
        sent_x[lay] = sx;
        sent_y[lay] = sy;
    endtask

    // mostly small moves from the last sent position, some jumps anywhere
    task automatic queue_random(input int count);
        logic        lay;
        logic [15:0] sx;
        logic [15:0] sy;
        int          mode;
        for (int n = 0; n < count; n++) begin
            lay  = 1'($urandom_range(1));
            mode = $urandom_range(99);
            sx   = sent_x[lay];
            sy   = sent_y[lay];
            if (mode < 55) begin
                sx = sx + 16'($urandom_range(96)) - 16'd48;
                sy = sy + 16'($urandom_range(96)) - 16'd48;
            end else if (mode < 65) begin
                sx = {sx[15:3], 3'($urandom_range(7))};
                sy = {sy[15:3], 3'($urandom_range(7))};
            end else if (mode < 75) begin
                if ($urandom_range(1) == 0) sx = sx + 16'($urandom_range(160)) - 16'd80;
                else sy = sy + 16'($urandom_range(160)) - 16'd80;
            end else if (mode < 88) begin
                sx = sx + 16'($urandom_range(800)) - 16'd400;
                sy = sy + 16'($urandom_range(800)) - 16'd400;
            end else begin
                sx = 16'($urandom_range(65535));
                sy = 16'($urandom_range(65535));
            end
            queue_update(lay, sx, sy);
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || s_tvalid) @(negedge i_clk);
        while (redraw_q.size() != 0) @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pend_q[0].sy, pend_q[0].sx};
                s_tuser  <= pend_q[0].layer;
                void'(pend_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
                s_tdata  <= 32'($urandom);
                s_tuser  <= 1'($urandom_range(1));
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on each request taken, check each command delivered
    always @(posedge i_clk) begin
        redraw_cmd_t want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) predict_redraw(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) begin
                if (redraw_q.size() == 0) begin
                    note_mismatch("command with none expected, line_index",
                                  int'($signed(m_tdata[14:0])), 0);
                end else begin
                    want = redraw_q.pop_front();
                    if (m_tuser[0] !== want.out_layer)
                        note_mismatch("out_layer", int'(m_tuser[0]), int'(want.out_layer));
                    if (m_tuser[1] !== want.kind)
                        note_mismatch("kind", int'(m_tuser[1]), int'(want.kind));
                    if (m_tdata[14:0] !== want.line_index)
                        note_mismatch("line_index", int'($signed(m_tdata[14:0])),
                                      int'(want.line_index));
                    if (m_tdata[29:15] !== want.span_first)
                        note_mismatch("span_first", int'($signed(m_tdata[29:15])),
                                      int'(want.span_first));
                    if (m_tdata[44:30] !== want.span_end)
                        note_mismatch("span_end", int'($signed(m_tdata[44:30])),
                                      int'(want.span_end));
                    if (m_tlast !== want.last)
                        note_mismatch("last", int'(m_tlast), int'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int l = 0; l < 2; l++) begin
            redrawn_x[l] = '0;
            redrawn_y[l] = '0;
            sent_x[l]    = '0;
            sent_y[l]    = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles often less than the receiver
        send_idle_pct = 27;
        recv_idle_pct = 88;
        queue_update(1'b0, 16'd0, 16'd0);          // no move at all
        queue_update(1'b0, 16'd7, 16'd7);          // pixel move inside one tile
        queue_update(1'b0, 16'd8, 16'd0);          // one column right
        queue_update(1'b0, 16'd0, 16'd0);          // one column left, negative edge
        queue_update(1'b0, 16'd0, 16'd8);          // one row down
        queue_update(1'b0, 16'd0, 16'd0);          // one row up
        queue_update(1'b0, 16'd288, 16'd0);        // exactly the column window
        queue_update(1'b0, 16'd0, 16'd0);
        queue_update(1'b0, 16'd296, 16'd216);      // one past both windows
        queue_update(1'b0, 16'hFFFF, 16'hFFFF);    // to the far corner
        queue_update(1'b0, 16'hFFF8, 16'hFFF8);
        queue_update(1'b0, 16'd0, 16'd0);          // huge move back
        queue_update(1'b1, 16'd40, 16'd0);
        queue_update(1'b1, 16'd40, 16'd200);
        queue_update(1'b1, 16'd16, 16'd208);
        queue_update(1'b1, 16'h5555, 16'hAAAA);
        queue_update(1'b1, 16'hAAAA, 16'h5555);
        queue_update(1'b0, 16'h8000, 16'h7FFF);
        queue_update(1'b1, 16'd0, 16'd0);
        queue_update(1'b0, 16'd0, 16'd0);
        queue_random(120);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 27;
        queue_random(120);
        wait_drained();

        // no idling; long output stall first so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(140);
        hold_req <= hold_req + 1;
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_cnt == 0 && redraw_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[tilemap_scroll_edge_streamer_unit.f]
+incdir+hdl
hdl/tses_pkg.sv
hdl/tses_alu.sv
hdl/tses_pos_store.sv
hdl/tilemap_scroll_edge_streamer_unit.sv
dv/tb_tilemap_scroll_edge_streamer_unit.sv
